@@ rtl/nmf_pkg.sv @@
// Shared types and constants of the 3x3 neighbor mean filter.
package nmf_pkg;

  // Configuration register width (side length field)
  localparam int CFG_W = 11;
  localparam int MIN_SIDE = 2;

  // Divisor select codes for the rounded mean
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_BY_4 = 2'd0;
  localparam div_sel_t DIV_BY_6 = 2'd1;
  localparam div_sel_t DIV_BY_9 = 2'd2;

  // Result queue sizing: six pipeline slots of two lanes each can be in flight
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW = 4;
  localparam int FIFO_CW = FIFO_AW + 1;
  localparam int IN_FLIGHT = 12;
  localparam int STALL_LIMIT = FIFO_DEPTH - IN_FLIGHT;

  // Tag that travels with each result lane
  typedef struct packed {
    logic valid;
    logic last;
    logic eof;
  } nmf_tag_t;

endpackage

@@ rtl/neighbor_mean_filter_3x3_unit.sv @@
// Top level of the streaming 3x3 neighbor mean filter.
// Streaming 3x3 box blur over a square map sent in raster order: every push item
// carries one sample, every result is the rounded mean of the in-map neighbors of
// one sample (4 at corners, 6 on edges, 9 inside). Results trail the input by one
// row and one column; a push at the end of a row after the first gives two
// results, and after the last row one drain item per column gives the bottom row.
// One item is taken every clock while in_stall is low; each push issues one read
// of the two row stores and a write-back in the next cycle, so the row-store port
// sets that rate. Results leave a 16-entry queue; in_stall rises when the
// queue cannot absorb the results still in the pipeline, which happens only
// when out_stall holds results back or a row end adds its extra result. Pushes
// after the frame is complete and drains before it is complete are taken and
// give nothing. Writing side_length (clamped to 2..MAX_SIDE) restarts the frame.
// No clearing pass runs after reset.
module neighbor_mean_filter_3x3_unit #(
  parameter int MAX_SIDE = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [SAMPLE_BITS-1:0]    in_height_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SAMPLE_BITS-1:0]    out_mean_height,
  output logic                      out_last_in_run,
  output logic                      out_end_of_frame,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [nmf_pkg::CFG_W-1:0] cfg_side_length
);

  localparam int ADDR_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W = $clog2(MAX_SIDE + 1);
  localparam int XW = CNT_W + 1;
  localparam int VW = (CNT_W > nmf_pkg::CFG_W) ? CNT_W : nmf_pkg::CFG_W;
  localparam int SUM_W = SAMPLE_BITS + 4;
  localparam int CS_W = SAMPLE_BITS + 1;
  localparam int C3_W = SAMPLE_BITS + 2;
  localparam int RESET_SIDE = (MAX_SIDE < 256) ? MAX_SIDE : 256;

  typedef struct packed {
    logic push;
    logic drain;
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
    logic cap0;
    logic cap1;
    logic k_gt0;
    logic k_hi;
    logic k_last;
  } s1_ctl_t;

  // Frame counters and configuration
  logic [CNT_W-1:0]  side_r;
  logic [CNT_W-1:0]  row_r;
  logic [ADDR_W-1:0] col_r;
  logic [CNT_W-1:0]  drain_r;
  logic [VW-1:0]     cfg_ext;
  logic [CNT_W-1:0]  side_nxt;
  logic              cfg_wr;

  logic [XW-1:0]     side_x;
  logic [XW-1:0]     row_x;
  logic [XW-1:0]     col_x;
  logic [XW-1:0]     drain_x;
  logic [XW-1:0]     drain_addr_x;
  logic              in_acc;
  logic              frame_done;
  logic              push_go;
  logic              drain_go;
  logic              col_last;
  logic              drain_last;
  logic              drain_rd_ok;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  s1_ctl_t           s1_nxt;

  // Stage 1
  s1_ctl_t                s1_r;
  logic [SAMPLE_BITS-1:0] s1_x_r;
  logic [ADDR_W-1:0]      s1_col_r;
  logic [SAMPLE_BITS-1:0] rd_older;
  logic [SAMPLE_BITS-1:0] rd_newer;
  logic [SAMPLE_BITS-1:0] win_r [3][3];
  logic [CS_W-1:0]        cs0_r;
  logic [CS_W-1:0]        cs1_r;
  logic [CS_W-1:0]        cs2_r;
  logic [CS_W-1:0]        cap_sum;
  logic [SUM_W-1:0]       dsum_nxt;
  nmf_pkg::nmf_tag_t      tag_a_nxt;
  nmf_pkg::nmf_tag_t      tag_b_nxt;
  nmf_pkg::div_sel_t      sel_a_nxt;
  nmf_pkg::div_sel_t      sel_b_nxt;

  // Stage 2
  nmf_pkg::nmf_tag_t      s2_tag_a_r;
  nmf_pkg::nmf_tag_t      s2_tag_b_r;
  nmf_pkg::div_sel_t      s2_sel_a_r;
  nmf_pkg::div_sel_t      s2_sel_b_r;
  logic                   s2_drain_r;
  logic                   s2_rows3_r;
  logic                   s2_cols3_r;
  logic [SUM_W-1:0]       s2_dsum_r;
  logic [C3_W-1:0]        col_sum [3];
  logic [SUM_W-1:0]       win_a;
  logic [SUM_W-1:0]       win_b;

  // Stage 3
  nmf_pkg::nmf_tag_t      s3_tag_a_r;
  nmf_pkg::nmf_tag_t      s3_tag_b_r;
  nmf_pkg::div_sel_t      s3_sel_a_r;
  nmf_pkg::div_sel_t      s3_sel_b_r;
  logic [SUM_W-1:0]       s3_sum_a_r;
  logic [SUM_W-1:0]       s3_sum_b_r;

  nmf_pkg::nmf_tag_t      div_tag_a;
  nmf_pkg::nmf_tag_t      div_tag_b;
  logic [SAMPLE_BITS-1:0] div_mean_a;
  logic [SAMPLE_BITS-1:0] div_mean_b;
  logic [nmf_pkg::FIFO_CW-1:0] fifo_used;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (fifo_used > nmf_pkg::FIFO_CW'(nmf_pkg::STALL_LIMIT));
  assign in_acc    = in_valid && !in_stall;

  // Clamp the side length
  always_comb begin
    cfg_ext = VW'(cfg_side_length);
    if (cfg_ext < VW'(nmf_pkg::MIN_SIDE)) begin
      side_nxt = CNT_W'(nmf_pkg::MIN_SIDE);
    end else if (cfg_ext > VW'(MAX_SIDE)) begin
      side_nxt = CNT_W'(MAX_SIDE);
    end else begin
      side_nxt = cfg_ext[CNT_W-1:0];
    end
  end

  // Decode the item against the frame position
  always_comb begin
    side_x       = XW'(side_r);
    row_x        = XW'(row_r);
    col_x        = XW'(col_r);
    drain_x      = XW'(drain_r);
    drain_addr_x = drain_x + XW'(2);
    frame_done   = (row_x >= side_x);
    push_go      = in_acc && !in_action && !frame_done;
    drain_go     = in_acc && in_action && frame_done && (drain_x < side_x);
    col_last     = (col_x + XW'(1) >= side_x);
    drain_last   = (drain_x + XW'(1) == side_x);
    drain_rd_ok  = (drain_addr_x < side_x);
    rd_en        = push_go || (drain_go && drain_rd_ok);
    rd_addr      = push_go ? col_r : drain_addr_x[ADDR_W-1:0];

    s1_nxt.push   = push_go;
    s1_nxt.drain  = drain_go;
    s1_nxt.r_ge1  = (row_r != '0);
    s1_nxt.r_ge2  = (row_x >= XW'(2));
    s1_nxt.c_ge1  = (col_r != '0);
    s1_nxt.c_ge2  = (col_x >= XW'(2));
    s1_nxt.c_last = (col_x + XW'(1) == side_x);
    s1_nxt.cap0   = (row_x + XW'(1) == side_x) && (col_r == '0);
    s1_nxt.cap1   = (row_x + XW'(1) == side_x) && (col_x == XW'(1));
    s1_nxt.k_gt0  = (drain_r != '0);
    s1_nxt.k_hi   = (drain_x + XW'(1) < side_x);
    s1_nxt.k_last = drain_last;
  end

  // Advance the frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= CNT_W'(RESET_SIDE);
      row_r   <= '0;
      col_r   <= '0;
      drain_r <= '0;
    end else if (cfg_wr) begin
      side_r  <= side_nxt;
      row_r   <= '0;
      col_r   <= '0;
      drain_r <= '0;
    end else if (push_go) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_r + CNT_W'(1);
      end else begin
        col_r <= col_r + ADDR_W'(1);
      end
    end else if (drain_go) begin
      if (drain_last) begin
        row_r   <= '0;
        col_r   <= '0;
        drain_r <= '0;
      end else begin
        drain_r <= drain_r + CNT_W'(1);
      end
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r   <= in_height_in;
    s1_col_r <= col_r;
  end

  nmf_line_store #(
    .MAX_SIDE    (MAX_SIDE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (s1_r.push),
    .wr_addr  (s1_col_r),
    .wr_older (rd_newer),
    .wr_newer (s1_x_r),
    .rd_older (rd_older),
    .rd_newer (rd_newer)
  );

  // Shift the new column into the window
  always_ff @(posedge clk) begin
    if (s1_r.push) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= rd_older;
      win_r[1][2] <= rd_newer;
      win_r[2][2] <= s1_x_r;
    end
  end

  // Bottom-row column sums: capture the first two, then shift on each drain
  assign cap_sum = {1'b0, rd_newer} + {1'b0, s1_x_r};

  always_ff @(posedge clk) begin
    if (s1_r.push && s1_r.cap0) begin
      cs1_r <= cap_sum;
    end else if (s1_r.push && s1_r.cap1) begin
      cs2_r <= cap_sum;
    end else if (s1_r.drain) begin
      cs0_r <= cs1_r;
      cs1_r <= cs2_r;
      cs2_r <= {1'b0, rd_older} + {1'b0, rd_newer};
    end
  end

  // Result lanes, divisors and the drain sum
  always_comb begin
    dsum_nxt = (s1_r.k_gt0 ? SUM_W'(cs0_r) : '0) + SUM_W'(cs1_r)
             + (s1_r.k_hi ? SUM_W'(cs2_r) : '0);
    if (s1_r.drain) begin
      tag_a_nxt = '{valid: 1'b1, last: 1'b1, eof: s1_r.k_last};
      tag_b_nxt = '0;
      sel_a_nxt = (s1_r.k_gt0 && s1_r.k_hi) ? nmf_pkg::DIV_BY_6 : nmf_pkg::DIV_BY_4;
      sel_b_nxt = nmf_pkg::DIV_BY_4;
    end else begin
      tag_a_nxt.valid = s1_r.push && s1_r.r_ge1 && s1_r.c_ge1;
      tag_a_nxt.last  = !(s1_r.r_ge1 && s1_r.c_last);
      tag_a_nxt.eof   = 1'b0;
      tag_b_nxt.valid = s1_r.push && s1_r.r_ge1 && s1_r.c_last;
      tag_b_nxt.last  = 1'b1;
      tag_b_nxt.eof   = 1'b0;
      if (s1_r.r_ge2 && s1_r.c_ge2) begin
        sel_a_nxt = nmf_pkg::DIV_BY_9;
      end else if (s1_r.r_ge2 || s1_r.c_ge2) begin
        sel_a_nxt = nmf_pkg::DIV_BY_6;
      end else begin
        sel_a_nxt = nmf_pkg::DIV_BY_4;
      end
      sel_b_nxt = s1_r.r_ge2 ? nmf_pkg::DIV_BY_6 : nmf_pkg::DIV_BY_4;
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_a_r <= '0;
      s2_tag_b_r <= '0;
    end else begin
      s2_tag_a_r <= tag_a_nxt;
      s2_tag_b_r <= tag_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_sel_a_r <= sel_a_nxt;
    s2_sel_b_r <= sel_b_nxt;
    s2_drain_r <= s1_r.drain;
    s2_rows3_r <= s1_r.r_ge2;
    s2_cols3_r <= s1_r.c_ge2;
    s2_dsum_r  <= dsum_nxt;
  end

  // Masked window sums
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      col_sum[j] = (s2_rows3_r ? C3_W'(win_r[0][j]) : '0) + C3_W'(win_r[1][j])
                 + C3_W'(win_r[2][j]);
    end
    win_a = (s2_cols3_r ? SUM_W'(col_sum[0]) : '0) + SUM_W'(col_sum[1])
          + SUM_W'(col_sum[2]);
    win_b = SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
  end

  // Stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_a_r <= '0;
      s3_tag_b_r <= '0;
    end else begin
      s3_tag_a_r <= s2_tag_a_r;
      s3_tag_b_r <= s2_tag_b_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sel_a_r <= s2_sel_a_r;
    s3_sel_b_r <= s2_sel_b_r;
    s3_sum_a_r <= s2_drain_r ? s2_dsum_r : win_a;
    s3_sum_b_r <= win_b;
  end

  nmf_mean_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (s3_tag_a_r),
    .in_sum   (s3_sum_a_r),
    .in_sel   (s3_sel_a_r),
    .out_tag  (div_tag_a),
    .out_mean (div_mean_a)
  );

  nmf_mean_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (s3_tag_b_r),
    .in_sum   (s3_sum_b_r),
    .in_sel   (s3_sel_b_r),
    .out_tag  (div_tag_b),
    .out_mean (div_mean_b)
  );

  nmf_result_fifo #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_tag_a  (div_tag_a),
    .wr_mean_a (div_mean_a),
    .wr_tag_b  (div_tag_b),
    .wr_mean_b (div_mean_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_mean  (out_mean_height),
    .out_last  (out_last_in_run),
    .out_eof   (out_end_of_frame),
    .used      (fifo_used)
  );

endmodule

@@ rtl/nmf_line_store.sv @@
// Two row stores with registered read and write-to-read forwarding.
module nmf_line_store #(
  parameter int MAX_SIDE = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int ADDR_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_older,
  input  logic [SAMPLE_BITS-1:0] wr_newer,
  output logic [SAMPLE_BITS-1:0] rd_older,
  output logic [SAMPLE_BITS-1:0] rd_newer
);

  logic [SAMPLE_BITS-1:0] mem_older [MAX_SIDE];
  logic [SAMPLE_BITS-1:0] mem_newer [MAX_SIDE];
  logic [SAMPLE_BITS-1:0] q_older_r;
  logic [SAMPLE_BITS-1:0] q_newer_r;
  logic [SAMPLE_BITS-1:0] fwd_older_r;
  logic [SAMPLE_BITS-1:0] fwd_newer_r;
  logic                   fwd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_older[wr_addr] <= wr_older;
      mem_newer[wr_addr] <= wr_newer;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_older_r <= mem_older[rd_addr];
      q_newer_r <= mem_newer[rd_addr];
    end
  end

  // Capture write data when a read hits the entry being written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_older_r <= wr_older;
      fwd_newer_r <= wr_newer;
    end
  end

  assign rd_older = fwd_r ? fwd_older_r : q_older_r;
  assign rd_newer = fwd_r ? fwd_newer_r : q_newer_r;

endmodule

@@ rtl/nmf_mean_div.sv @@
// Two-stage rounded division of a neighborhood sum by 4, 6 or 9.
module nmf_mean_div #(
  parameter int SAMPLE_BITS = 16,
  localparam int SUM_W = SAMPLE_BITS + 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nmf_pkg::nmf_tag_t      in_tag,
  input  logic [SUM_W-1:0]       in_sum,
  input  nmf_pkg::div_sel_t      in_sel,
  output nmf_pkg::nmf_tag_t      out_tag,
  output logic [SAMPLE_BITS-1:0] out_mean
);

  localparam int NW = SUM_W + 1;
  localparam logic [NW:0] Pow = {1'b1, {NW{1'b0}}};
  localparam logic [NW-1:0] RECIP_3 = NW'(Pow / 3);
  localparam logic [NW-1:0] RECIP_9 = NW'(Pow / 9);
  localparam int QW = NW + 4;

  logic [NW-1:0]     n_ext;
  logic [NW-1:0]     n_val;
  logic [NW-1:0]     recip;
  logic [2*NW-1:0]   prod;
  logic [NW-1:0]     q_est;

  nmf_pkg::nmf_tag_t a_tag_r;
  nmf_pkg::div_sel_t a_sel_r;
  logic [NW-1:0]     a_n_r;
  logic [NW-1:0]     a_q_r;

  logic [QW-1:0]     qd;
  logic [QW-1:0]     rem;
  logic [QW-1:0]     dval;
  logic              fix;
  logic [NW-1:0]     q_fin;

  nmf_pkg::nmf_tag_t out_tag_r;
  logic [SAMPLE_BITS-1:0] out_mean_r;

  // Add the rounding bias; fold the factor 2 of six into a shift
  always_comb begin
    n_ext = {1'b0, in_sum};
    unique case (in_sel)
      nmf_pkg::DIV_BY_4: begin
        n_val = (n_ext + NW'(2)) >> 2;
        recip = '0;
      end
      nmf_pkg::DIV_BY_6: begin
        n_val = (n_ext + NW'(3)) >> 1;
        recip = RECIP_3;
      end
      nmf_pkg::DIV_BY_9: begin
        n_val = n_ext + NW'(4);
        recip = RECIP_9;
      end
      default: begin
        n_val = '0;
        recip = '0;
      end
    endcase
    prod = {{NW{1'b0}}, n_val} * {{NW{1'b0}}, recip};
    q_est = (in_sel == nmf_pkg::DIV_BY_4) ? n_val : prod[2*NW-1:NW];
  end

  // Stage A: quotient estimate, low by at most one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
    end else begin
      a_tag_r <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    a_sel_r <= in_sel;
    a_n_r   <= n_val;
    a_q_r   <= q_est;
  end

  // Stage B: remainder check and correction
  always_comb begin
    if (a_sel_r == nmf_pkg::DIV_BY_9) begin
      qd   = {a_q_r, 3'b000} + QW'(a_q_r);
      dval = QW'(9);
    end else begin
      qd   = QW'({a_q_r, 1'b0}) + QW'(a_q_r);
      dval = QW'(3);
    end
    rem = QW'(a_n_r) - qd;
    fix = (a_sel_r != nmf_pkg::DIV_BY_4) && (rem >= dval);
    q_fin = a_q_r + NW'(fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tag_r <= '0;
    end else begin
      out_tag_r <= a_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    out_mean_r <= q_fin[SAMPLE_BITS-1:0];
  end

  assign out_tag  = out_tag_r;
  assign out_mean = out_mean_r;

endmodule

@@ rtl/nmf_result_fifo.sv @@
// Result queue taking up to two items per cycle and giving one per cycle while out_stall is low.
module nmf_result_fifo #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nmf_pkg::nmf_tag_t           wr_tag_a,
  input  logic [SAMPLE_BITS-1:0]      wr_mean_a,
  input  nmf_pkg::nmf_tag_t           wr_tag_b,
  input  logic [SAMPLE_BITS-1:0]      wr_mean_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SAMPLE_BITS-1:0]      out_mean,
  output logic                        out_last,
  output logic                        out_eof,
  output logic [nmf_pkg::FIFO_CW-1:0] used
);

  logic [SAMPLE_BITS-1:0]      mean_q [nmf_pkg::FIFO_DEPTH];
  logic                        last_q [nmf_pkg::FIFO_DEPTH];
  logic                        eof_q  [nmf_pkg::FIFO_DEPTH];
  logic [nmf_pkg::FIFO_AW-1:0] wptr_r;
  logic [nmf_pkg::FIFO_AW-1:0] wptr_b;
  logic [nmf_pkg::FIFO_AW-1:0] rptr_r;
  logic [nmf_pkg::FIFO_CW-1:0] used_r;
  logic [nmf_pkg::FIFO_CW-1:0] used_nxt;
  logic                        rd;

  assign rd     = out_valid && !out_stall;
  assign wptr_b = wptr_r + nmf_pkg::FIFO_AW'(wr_tag_a.valid);

  // Store up to two items
  always_ff @(posedge clk) begin
    if (wr_tag_a.valid) begin
      mean_q[wptr_r] <= wr_mean_a;
      last_q[wptr_r] <= wr_tag_a.last;
      eof_q[wptr_r]  <= wr_tag_a.eof;
    end
    if (wr_tag_b.valid) begin
      mean_q[wptr_b] <= wr_mean_b;
      last_q[wptr_b] <= wr_tag_b.last;
      eof_q[wptr_b]  <= wr_tag_b.eof;
    end
  end

  assign used_nxt = used_r + nmf_pkg::FIFO_CW'(wr_tag_a.valid)
                  + nmf_pkg::FIFO_CW'(wr_tag_b.valid) - nmf_pkg::FIFO_CW'(rd);

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      used_r <= '0;
    end else begin
      wptr_r <= wptr_r + nmf_pkg::FIFO_AW'(wr_tag_a.valid)
              + nmf_pkg::FIFO_AW'(wr_tag_b.valid);
      rptr_r <= rptr_r + nmf_pkg::FIFO_AW'(rd);
      used_r <= used_nxt;
    end
  end

  assign out_valid = (used_r != '0);
  assign out_mean  = mean_q[rptr_r];
  assign out_last  = last_q[rptr_r];
  assign out_eof   = eof_q[rptr_r];
  assign used      = used_r;

endmodule

@@ dv/neighbor_mean_filter_3x3_unit_tb.sv @@
// Self-checking testbench of the 3x3 neighbor mean filter: scoreboard against a local blur predictor.
module neighbor_mean_filter_3x3_unit_tb;

  localparam int MAX_SIDE = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W = nmf_pkg::CFG_W;
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t mean;
    logic    last;
    logic    eof;
  } blur_result_t;
  typedef struct packed {
    logic    act;
    sample_t height;
  } stim_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_action = 1'b0;
  sample_t          in_height_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  sample_t          out_mean_height;
  logic             out_last_in_run;
  logic             out_end_of_frame;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_side_length = '0;

  neighbor_mean_filter_3x3_unit #(
    .MAX_SIDE(MAX_SIDE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_height_in(in_height_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_mean_height(out_mean_height),
    .out_last_in_run(out_last_in_run),
    .out_end_of_frame(out_end_of_frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_side_length(cfg_side_length)
  );

  // Predictor state of the blur
  sample_t     older_row [MAX_SIDE];
  sample_t     newer_row [MAX_SIDE];
  sample_t     win [9];
  int unsigned rows_in;
  int unsigned col_pos;
  int unsigned drains_done;
  int unsigned side_now;

  blur_result_t expected_means[$];

  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_hold_len = 0;
  int unsigned items_sent = 0;
  int unsigned items_used = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;
  int unsigned side_writes = 0;
  int unsigned errors = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_blur_state();
    int unsigned n;
    for (n = 0; n < MAX_SIDE; n++) begin
      older_row[n] = '0;
      newer_row[n] = '0;
    end
    for (n = 0; n < 9; n++) win[n] = '0;
    side_now = 256;
    rows_in = 0;
    col_pos = 0;
    drains_done = 0;
  endfunction

  function automatic void apply_side(logic [CFG_W-1:0] v);
    int unsigned val;
    val = v;
    if (val < nmf_pkg::MIN_SIDE) val = nmf_pkg::MIN_SIDE;
    if (val > MAX_SIDE) val = MAX_SIDE;
    side_now = val;
    rows_in = 0;
    col_pos = 0;
    drains_done = 0;
  endfunction

  // Round to nearest, halves up
  function automatic sample_t rounded_avg(int unsigned sum, int unsigned cnt);
    return sample_t'((sum + cnt / 2) / cnt);
  endfunction

  function automatic sample_t window_avg(int unsigned row_lo, int unsigned col_lo);
    int unsigned sum, cnt, i, j;
    sum = 0;
    cnt = 0;
    for (i = row_lo; i < 3; i++) begin
      for (j = col_lo; j < 3; j++) begin
        sum += win[i*3+j];
        cnt++;
      end
    end
    return rounded_avg(sum, cnt);
  endfunction

  function automatic sample_t last_row_avg(int unsigned k);
    int unsigned sum, cnt, lo, hi, n;
    sum = 0;
    cnt = 0;
    lo = (k == 0) ? 0 : k - 1;
    hi = (k + 1 < side_now) ? k + 1 : side_now - 1;
    for (n = lo; n <= hi; n++) begin
      sum += older_row[n];
      sum += newer_row[n];
      cnt += 2;
    end
    return rounded_avg(sum, cnt);
  endfunction

  // Queue the means that one accepted item must produce
  function automatic void predict_blur(logic act, sample_t h);
    int unsigned r, c, row_lo, i;
    bit has_inner, has_row_end;
    blur_result_t res;
    if (act == ACT_DRAIN) begin
      // drop drains outside the bottom-row phase
      if (rows_in < side_now || drains_done >= side_now) return;
      res.mean = last_row_avg(drains_done);
      res.last = 1'b1;
      res.eof = (drains_done + 1 == side_now);
      expected_means.push_back(res);
      items_used++;
      if (res.eof) begin
        rows_in = 0;
        col_pos = 0;
        drains_done = 0;
      end else begin
        drains_done++;
      end
      return;
    end
    // drop pushes once the whole map is in
    if (rows_in >= side_now) return;
    items_used++;
    r = rows_in;
    c = col_pos;
    for (i = 0; i < 3; i++) begin
      win[i*3+0] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = older_row[c];
    win[5] = newer_row[c];
    win[8] = h;
    older_row[c] = newer_row[c];
    newer_row[c] = h;
    if (r >= 1) begin
      row_lo = (r >= 2) ? 0 : 1;
      has_inner = (c >= 1);
      has_row_end = (c + 1 == side_now);
      if (has_inner) begin
        res.mean = window_avg(row_lo, (c >= 2) ? 0 : 1);
        res.last = !has_row_end;
        res.eof = 1'b0;
        expected_means.push_back(res);
      end
      if (has_row_end) begin
        res.mean = window_avg(row_lo, 1);
        res.last = 1'b1;
        res.eof = 1'b0;
        expected_means.push_back(res);
      end
    end
    if (c + 1 >= side_now) begin
      col_pos = 0;
      rows_in++;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic sample_t pick_height();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until taken
  task automatic send_item(logic act, sample_t h);
    if (src_idle_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_height_in <= h;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_blur(act, h);
    items_sent++;
  endtask

  task automatic wait_results_done(bit settle);
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_side(logic [CFG_W-1:0] v);
    wait_results_done(1'b1);
    cfg_valid <= 1'b1;
    cfg_side_length <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_side(v);
    side_writes++;
  endtask

  task automatic push_rows(int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_item(ACT_PUSH, pick_height());
  endtask

  task automatic drain_rows(int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_item(ACT_DRAIN, pick_height());
  endtask

  // Row length out of reset: one full row, then the start of the next
  task automatic test_reset_side();
    push_rows(256 + 8);
  endtask

  // Clamped sides, rounding of exact halves, full-scale samples, ignored items
  task automatic test_directed_corners();
    int unsigned k;
    set_side('0);
    send_item(ACT_DRAIN, '1);
    send_item(ACT_PUSH, 16'd0);
    send_item(ACT_PUSH, 16'd1);
    send_item(ACT_PUSH, 16'd1);
    send_item(ACT_PUSH, 16'd0);
    send_item(ACT_PUSH, '1);
    send_item(ACT_DRAIN, '0);
    send_item(ACT_DRAIN, '0);
    send_item(ACT_DRAIN, '0);
    set_side(11'd1);
    for (k = 0; k < 4; k++) send_item(ACT_PUSH, '1);
    drain_rows(2);
    set_side(11'd3);
    for (k = 0; k < 9; k++) send_item(ACT_PUSH, (k % 2 == 0) ? '1 : '0);
    drain_rows(3);
  endtask

  // One frame back to back on both sides
  task automatic test_full_stream();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    set_side(11'd6);
    push_rows(36);
    drain_rows(6);
    wait_results_done(1'b0);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Fill the result queue behind a long receiver hold-off, then pause the sender
  task automatic test_output_backpressure();
    set_side(11'd8);
    sink_hold_len = HOLD_OFF_CYCLES;
    push_rows(40);
    wait_results_done(1'b0);
    push_rows(24);
    drain_rows(8);
  endtask

  // Widest rows: exact maximum and a saturated write
  task automatic test_widest_rows();
    set_side(11'd1024);
    push_rows(2 * 1024);
    set_side('1);
    push_rows(1024 + 4);
  endtask

  // Mostly well-formed small frames, some noise and cut-off frames
  task automatic test_random_frames();
    int unsigned start_items, sz, cut, k;
    stim_t frame_items[$];
    stim_t one;
    bit frame_open;
    start_items = items_used;
    frame_open = 1'b1;
    while (items_used - start_items < RANDOM_ITEMS) begin
      if (!frame_open && $urandom_range(2) == 0) begin
        sz = side_now;
      end else begin
        sz = ($urandom_range(7) == 0) ? $urandom_range(9, 14) : $urandom_range(2, 8);
        if (sz == 2 && $urandom_range(1) == 1) set_side($urandom_range(0, 1));
        else set_side(sz);
      end
      frame_items.delete();
      for (k = 0; k < sz * sz; k++) begin
        if ($urandom_range(19) == 0) begin
          one.act = ACT_DRAIN;
          one.height = pick_height();
          frame_items.push_back(one);
        end
        one.act = ACT_PUSH;
        one.height = pick_height();
        frame_items.push_back(one);
      end
      if ($urandom_range(3) == 0) begin
        one.act = ACT_PUSH;
        one.height = pick_height();
        frame_items.push_back(one);
      end
      for (k = 0; k < sz; k++) begin
        one.act = ACT_DRAIN;
        one.height = pick_height();
        frame_items.push_back(one);
      end
      if ($urandom_range(3) == 0) begin
        one.act = ACT_DRAIN;
        one.height = pick_height();
        frame_items.push_back(one);
      end
      cut = frame_items.size();
      frame_open = 1'b0;
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, frame_items.size() - 1);
        frame_open = 1'b1;
      end
      for (k = 0; k < cut; k++) begin
        if ($urandom_range(149) == 0) wait_results_done(1'b0);
        send_item(frame_items[k].act, frame_items[k].height);
      end
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_len != 0) begin
        hold_left = sink_hold_len;
        sink_hold_len = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= sink_idle_on && ($urandom_range(99) < 18);
      end
    end
  end

  // Compare each taken result with the oldest expected mean
  always @(posedge clk) begin : check_results
    blur_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result: mean_height %0d", out_mean_height);
        errors++;
      end else begin
        want = expected_means.pop_front();
        results_seen++;
        if (out_mean_height !== want.mean) begin
          $error("mean_height: expected %0d, actual %0d", want.mean, out_mean_height);
          errors++;
        end
        if (out_last_in_run !== want.last) begin
          $error("last_in_run: expected %0b, actual %0b", want.last, out_last_in_run);
          errors++;
        end
        if (out_end_of_frame !== want.eof) begin
          $error("end_of_frame: expected %0b, actual %0b", want.eof, out_end_of_frame);
          errors++;
        end
        if (want.eof) frames_done++;
      end
    end
  end

  // Stop the run when no channel moves for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_stall === 1'b0) ||
          (out_valid === 1'b1 && !out_stall) || (cfg_valid && cfg_ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no progress for %0d cycles, %0d results outstanding",
           WATCHDOG_LIMIT, expected_means.size());
    $display("neighbor_mean_filter_3x3_unit_tb: errors");
    $finish;
  end

  initial begin
    clear_blur_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_side();
    test_directed_corners();
    test_full_stream();
    test_output_backpressure();
    test_widest_rows();
    test_random_frames();
    wait_results_done(1'b1);
    $display("run: %0d items sent (%0d effective), %0d results checked, %0d frames closed",
             items_sent, items_used, results_seen, frames_done);
    $display("run: %0d side_length writes, sides 2 to 1024, hold-off and sender pause done",
             side_writes);
    if (errors == 0) begin
      $display("neighbor_mean_filter_3x3_unit_tb: clean");
    end else begin
      $display("neighbor_mean_filter_3x3_unit_tb: errors");
    end
    $finish;
  end

endmodule
